### hw/rtl/bmw_pkg.sv
// Shared types and constants for the binary morphology window block.
// Register codes, input opcodes, element and per-transaction control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmw_pkg;

    localparam int ELEM_SPAN   = 7;
    localparam int MASK_BITS   = 49;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_ELEMENT_ROWS   = 3'd2,
        REG_ELEMENT_COLS   = 3'd3,
        REG_ORIGIN_ROW     = 3'd4,
        REG_ORIGIN_COL     = 3'd5,
        REG_ELEMENT_MASK   = 3'd6,
        REG_OPERATION_MODE = 3'd7
    } bmw_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } bmw_op_t;

    typedef enum logic {
        MODE_DILATE = 1'b0,
        MODE_ERODE  = 1'b1
    } bmw_mode_t;

    // tap_mask is in window coordinates: bit i*ELEM_SPAN+j is the tap i rows
    // and j columns behind the newest pixel
    typedef struct packed {
        logic                 erode;
        logic [2:0]           lead_r;
        logic [2:0]           lead_c;
        logic [MASK_BITS-1:0] tap_mask;
    } bmw_elem_t;

    typedef struct packed {
        logic                 fg;
        logic                 emit;
        logic                 last;
        logic [ELEM_SPAN-1:0] row_ok;
        logic [ELEM_SPAN-1:0] col_ok;
    } bmw_item_t;

endpackage

`default_nettype wire

### hw/rtl/bmw_config.sv
// Configuration registers and derived geometry of the morphology window.
// Depends on bmw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmw_config #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_ELEMENT = 7,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int DLW = $clog2((MAX_ELEMENT - 1) * MAX_WIDTH + MAX_ELEMENT + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [48:0]         cfg_data,
    output logic                     restart,
    output logic [WW-1:0]            width,
    output logic [HW-1:0]            height,
    output logic [DLW-1:0]           delay,
    output bmw_pkg::bmw_elem_t       elem
);

    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [2:0]  erows_reg, erows_next;
    logic [2:0]  ecols_reg, ecols_next;
    logic [2:0]  orow_reg, orow_next;
    logic [2:0]  ocol_reg, ocol_next;
    logic [48:0] mask_reg, mask_next;
    logic        mode_reg, mode_next;

    logic [2:0]    er, ec, ro, co, lr, lc;
    logic          erode;
    logic [WW+2:0] prod;
    logic [bmw_pkg::MASK_BITS-1:0] tmask;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        erows_next  = erows_reg;
        ecols_next  = ecols_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        mask_next   = mask_reg;
        mode_next   = mode_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bmw_pkg::REG_IMAGE_WIDTH:    width_next  = cfg_data[10:0];
                bmw_pkg::REG_IMAGE_HEIGHT:   height_next = cfg_data[10:0];
                bmw_pkg::REG_ELEMENT_ROWS:   erows_next  = cfg_data[2:0];
                bmw_pkg::REG_ELEMENT_COLS:   ecols_next  = cfg_data[2:0];
                bmw_pkg::REG_ORIGIN_ROW:     orow_next   = cfg_data[2:0];
                bmw_pkg::REG_ORIGIN_COL:     ocol_next   = cfg_data[2:0];
                bmw_pkg::REG_ELEMENT_MASK:   mask_next   = cfg_data;
                bmw_pkg::REG_OPERATION_MODE: mode_next   = cfg_data[0];
                default:                     mode_next   = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            erows_reg  <= 3'd3;
            ecols_reg  <= 3'd3;
            orow_reg   <= 3'd1;
            ocol_reg   <= 3'd1;
            mask_reg   <= '0;
            mode_reg   <= bmw_pkg::MODE_ERODE;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            erows_reg  <= erows_next;
            ecols_reg  <= ecols_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            mask_reg   <= mask_next;
            mode_reg   <= mode_next;
        end
    end

    // every index of the 3-bit port names a register, so any write restarts
    assign restart = cfg_write;

    always_comb
    begin
        if (width_reg == 11'd0)
            width = WW'(1);
        else if (width_reg > MAX_WIDTH)
            width = WW'(MAX_WIDTH);
        else
            width = WW'(width_reg);

        if (height_reg == 11'd0)
            height = HW'(1);
        else if (height_reg > MAX_HEIGHT)
            height = HW'(MAX_HEIGHT);
        else
            height = HW'(height_reg);

        if (erows_reg == 3'd0)
            er = 3'd1;
        else if (erows_reg > MAX_ELEMENT)
            er = 3'(MAX_ELEMENT);
        else
            er = erows_reg;

        if (ecols_reg == 3'd0)
            ec = 3'd1;
        else if (ecols_reg > MAX_ELEMENT)
            ec = 3'(MAX_ELEMENT);
        else
            ec = ecols_reg;

        ro    = (orow_reg < er) ? orow_reg : er - 3'd1;
        co    = (ocol_reg < ec) ? ocol_reg : ec - 3'd1;
        erode = (mode_reg == bmw_pkg::MODE_ERODE);
        lr    = erode ? er - 3'd1 - ro : ro;
        lc    = erode ? ec - 3'd1 - co : co;
        prod  = lr * width;
        delay = DLW'(prod + (WW+3)'(lc));
    end

    always_comb
    begin
        tmask = '0;
        for (int i = 0; i < bmw_pkg::ELEM_SPAN; i++)
        begin
            for (int j = 0; j < bmw_pkg::ELEM_SPAN; j++)
            begin
                if (i < int'(er) && j < int'(ec))
                begin
                    if (erode)
                        tmask[i*bmw_pkg::ELEM_SPAN+j] =
                            mask_reg[(int'(er)-1-i)*bmw_pkg::ELEM_SPAN + (int'(ec)-1-j)];
                    else
                        tmask[i*bmw_pkg::ELEM_SPAN+j] = mask_reg[i*bmw_pkg::ELEM_SPAN+j];
                end
                // erosion also needs the pixel under the origin
                if (erode && i == int'(lr) && j == int'(lc))
                    tmask[i*bmw_pkg::ELEM_SPAN+j] = 1'b1;
            end
        end
    end

    assign elem.erode    = erode;
    assign elem.lead_r   = lr;
    assign elem.lead_c   = lc;
    assign elem.tap_mask = tmask;

endmodule

`default_nettype wire

### hw/rtl/bmw_front.sv
// Front end: accepts transactions, tracks frame positions and classifies
// each item (foreground bit, result release, edge validity). Depends on bmw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmw_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_ELEMENT = 7,
    localparam int WW  = $clog2(MAX_WIDTH + 1),
    localparam int AW  = $clog2(MAX_WIDTH),
    localparam int HW  = $clog2(MAX_HEIGHT + 1),
    localparam int DLW = $clog2((MAX_ELEMENT - 1) * MAX_WIDTH + MAX_ELEMENT + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire logic                opcode,
    input  wire logic [7:0]          pixel_value,
    input  wire logic                restart,
    input  wire logic [WW-1:0]       width,
    input  wire logic [HW-1:0]       height,
    input  wire logic [DLW-1:0]      delay,
    input  wire bmw_pkg::bmw_elem_t  elem,
    input  wire logic                queue_full,
    output logic                     push,
    output bmw_pkg::bmw_item_t       item,
    output logic [AW-1:0]            col,
    output logic [AW-1:0]            next_col
);

    logic [AW-1:0]  in_col_reg, in_col_next;
    logic [HW-1:0]  in_row_reg, in_row_next;
    logic [AW-1:0]  out_col_reg, out_col_next;
    logic [HW-1:0]  out_row_reg, out_row_next;
    logic [DLW-1:0] pos_reg, pos_next;
    logic           started_reg, started_next;

    logic          in_frame, emit, last, wrap;
    logic [AW:0]   col_inc, ocol_inc;
    logic [HW:0]   tr;
    logic [AW:0]   tc;

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    always_comb
    begin
        in_frame = (in_row_reg < height);
        emit     = started_reg || (pos_reg == delay);
        last     = emit && (out_row_reg == height - 1'b1)
                        && ({1'b0, out_col_reg} == (AW+1)'(width) - 1'b1);
        col_inc  = {1'b0, in_col_reg} + 1'b1;
        wrap     = (col_inc == (AW+1)'(width));
        ocol_inc = {1'b0, out_col_reg} + 1'b1;
        tr       = {1'b0, out_row_reg} + (HW+1)'(elem.lead_r);
        tc       = {1'b0, out_col_reg} + (AW+1)'(elem.lead_c);

        item.fg   = in_frame && (opcode == bmw_pkg::OP_PIXEL) && (pixel_value != 8'd0);
        item.emit = emit;
        item.last = last;
        for (int i = 0; i < bmw_pkg::ELEM_SPAN; i++)
        begin
            item.row_ok[i] = (tr >= (HW+1)'(i))
                          && ((tr - (HW+1)'(i)) < {1'b0, height});
            item.col_ok[i] = (tc >= (AW+1)'(i))
                          && ((tc - (AW+1)'(i)) < (AW+1)'(width));
        end
        col      = in_col_reg;
        next_col = (last || wrap) ? '0 : col_inc[AW-1:0];
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pos_next     = '0;
            started_next = 1'b0;
        end
        else if (push)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                pos_next     = '0;
                started_next = 1'b0;
            end
            else
            begin
                in_col_next = next_col;
                if (wrap && in_frame)
                    in_row_next = in_row_reg + 1'b1;
                if (emit)
                begin
                    started_next = 1'b1;
                    if (ocol_inc == (AW+1)'(width))
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                        out_col_next = ocol_inc[AW-1:0];
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

`ifndef SYNTH
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        push && item.last |=> (out_row_reg == '0) && (out_col_reg == '0) && !started_reg)
        else $error("frame counters not cleared after last result");
`endif

endmodule

`default_nettype wire

### hw/rtl/bmw_queue.sv
// Two-entry queue that decouples the front end from the window engine.
// Depends on bmw_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module bmw_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wdata,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      rdata,
    output logic                   not_empty
);

    localparam int DEPTH = bmw_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [DATA_W-1:0] data_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= wdata;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### hw/rtl/bmw_back.sv
// Window engine: line buffers, column history, erosion/dilation test and the
// result register. Depends on bmw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmw_back #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_ELEMENT = 7,
    localparam int AW  = $clog2(MAX_WIDTH),
    localparam int LBW = (MAX_ELEMENT > 1) ? MAX_ELEMENT - 1 : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire bmw_pkg::bmw_item_t  q_item,
    input  wire logic [AW-1:0]       q_col,
    input  wire logic [AW-1:0]       q_next_col,
    output logic                     pop,
    input  wire bmw_pkg::bmw_elem_t  elem,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     result_bit,
    output logic                     last_of_frame
);

    logic [LBW-1:0] line_mem [MAX_WIDTH];
    logic [LBW-1:0] rdata_reg;
    logic [LBW-1:0] wdata;
    logic [LBW-1:0] hist_reg [MAX_ELEMENT];

    logic [MAX_ELEMENT-1:0] taps;
    logic                   win [MAX_ELEMENT][MAX_ELEMENT];
    logic                   res, all_ok, any_hit, v, m;
    logic                   out_can;

    logic result_valid_reg, result_valid_next;
    logic result_bit_reg, last_reg;

    always_comb
    begin
        taps[0] = q_item.fg;
        for (int i = 1; i < MAX_ELEMENT; i++)
            taps[i] = rdata_reg[i-1];
        for (int x = 0; x < LBW; x++)
            wdata[x] = taps[x];
        for (int i = 0; i < MAX_ELEMENT; i++)
        begin
            win[i][0] = taps[i];
            for (int j = 1; j < MAX_ELEMENT; j++)
                win[i][j] = hist_reg[i][j-1];
        end
    end

    always_comb
    begin
        all_ok  = 1'b1;
        any_hit = 1'b0;
        v       = 1'b0;
        m       = 1'b0;
        for (int i = 0; i < MAX_ELEMENT; i++)
        begin
            for (int j = 0; j < MAX_ELEMENT; j++)
            begin
                v = win[i][j] && q_item.row_ok[i] && q_item.col_ok[j];
                m = elem.tap_mask[i*bmw_pkg::ELEM_SPAN+j];
                all_ok  = all_ok && (!m || v);
                any_hit = any_hit || (m && v);
            end
        end
        res = elem.erode ? all_ok : any_hit;
    end

    assign out_can = !result_valid_reg || !result_stall;
    assign pop     = q_valid && (!q_item.emit || out_can);

    // one write and one look-ahead read per transaction
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            line_mem[q_col] <= wdata;
            rdata_reg <= (q_next_col == q_col) ? wdata : line_mem[q_next_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < MAX_ELEMENT; i++)
            begin
                hist_reg[i][0] <= taps[i];
                for (int x = 1; x < LBW; x++)
                    hist_reg[i][x] <= hist_reg[i][x-1];
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop && q_item.emit)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_item.emit)
        begin
            result_bit_reg <= res;
            last_reg       <= q_item.last;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result_bit    = result_bit_reg;
    assign last_of_frame = last_reg;

`ifndef SYNTH
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_item.emit |=> result_valid_reg)
        else $error("released result not presented");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |-> !(pop && q_item.emit))
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

### hw/rtl/binary_morphology_window.sv
// Top level of the binary morphology window: erosion/dilation with a
// programmable structuring element over a raster pixel stream.
// Depends on bmw_pkg, bmw_config, bmw_front, bmw_queue, bmw_back.
//
// The block takes one pixel transaction per clock while item_stall is low and
// gives one result per transaction once the window lead is reached: the result
// for pixel k is released by the transaction at frame position k + lead_r*W +
// lead_c and reaches the result port through the front classification, a
// two-entry queue and then the window engine and its output register.
// The rate is set by the line-buffer memory, which does one write and one
// look-ahead read per transaction; the window test itself is a
// single parallel AND/OR over the taps. Flush transactions push out the
// results still pending at the end of a frame; last_of_frame marks the final
// one, after which the next transaction starts a new frame. A configuration
// write restarts the frame and must be made only while the block is idle.
// No clearing pass is needed after reset: positions not yet written in the
// current frame are always outside the image and read as zero.
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_window #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_ELEMENT = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  pixel_value,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             result_bit,
    output logic             last_of_frame,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [48:0] cfg_data
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int DLW = $clog2((MAX_ELEMENT - 1) * MAX_WIDTH + MAX_ELEMENT + 1);
    localparam int IW  = $bits(bmw_pkg::bmw_item_t);
    localparam int QW  = IW + 2 * AW;

    logic               restart;
    logic [WW-1:0]      width;
    logic [HW-1:0]      height;
    logic [DLW-1:0]     delay;
    bmw_pkg::bmw_elem_t elem;

    logic               push, queue_full, q_valid, pop;
    bmw_pkg::bmw_item_t f_item, q_item;
    logic [AW-1:0]      f_col, f_next_col, q_col, q_next_col;
    logic [QW-1:0]      q_wdata, q_rdata;

    bmw_config #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_ELEMENT (MAX_ELEMENT)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .width     (width),
        .height    (height),
        .delay     (delay),
        .elem      (elem)
    );

    bmw_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_ELEMENT (MAX_ELEMENT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .opcode      (opcode),
        .pixel_value (pixel_value),
        .restart     (restart),
        .width       (width),
        .height      (height),
        .delay       (delay),
        .elem        (elem),
        .queue_full  (queue_full),
        .push        (push),
        .item        (f_item),
        .col         (f_col),
        .next_col    (f_next_col)
    );

    assign q_wdata    = {f_item, f_col, f_next_col};
    assign q_item     = bmw_pkg::bmw_item_t'(q_rdata[QW-1 -: IW]);
    assign q_col      = q_rdata[2*AW-1 -: AW];
    assign q_next_col = q_rdata[AW-1:0];

    bmw_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .full      (queue_full),
        .pop       (pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    bmw_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_ELEMENT (MAX_ELEMENT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_col         (q_col),
        .q_next_col    (q_next_col),
        .pop           (pop),
        .elem          (elem),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_bit    (result_bit),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

### verif/binary_morphology_window_tb.sv
// Self-checking testbench for binary_morphology_window: raster pixel transactions
// with random idling and stalls, checked against an in-bench erosion/dilation predictor.
// Depends on bmw_pkg and the binary_morphology_window RTL.
`timescale 1ns / 1ps

module binary_morphology_window_tb;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int MAXE       = 7;
    localparam int RING       = (MAXE - 1) * MAXW + MAXE + 1;
    localparam int SETTLE     = 8;
    localparam int LIMIT      = 300000;
    localparam int RAND_ITEMS = 1600;

    typedef enum int {K_ITEM, K_CFG, K_SYNC} pend_kind_t;

    typedef struct {
        pend_kind_t        kind;
        bmw_pkg::bmw_reg_t idx;
        logic [48:0]       data;
        bmw_pkg::bmw_op_t  op;
        logic [7:0]        pix;
    } pend_t;

    typedef struct {
        bit rb;
        bit lf;
    } morph_res_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        opcode;
    logic [7:0]  pixel_value;
    logic        result_valid;
    logic        result_stall;
    logic        result_bit;
    logic        last_of_frame;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [48:0] cfg_data;

    binary_morphology_window dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .opcode(opcode), .pixel_value(pixel_value),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_bit(result_bit), .last_of_frame(last_of_frame),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [10:0] m_width, m_height;
    logic [2:0]  m_erows, m_ecols, m_orow, m_ocol;
    logic [48:0] m_mask;
    logic        m_mode;
    bit          fg_ring [RING];
    int unsigned in_row, in_col, emitted;

    pend_t       pend_q [$];
    morph_res_t  morph_q [$];
    bit          in_acc;
    int          quiet;
    int          n_in, n_out, n_cfg, n_frames, mismatches;
    int          send_gap, recv_gap, long_hold;
    bit          hold_done;
    int unsigned cycles;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void frame_restart();
        foreach (fg_ring[i]) fg_ring[i] = 0;
        in_row = 0;
        in_col = 0;
        emitted = 0;
    endfunction

    function automatic void model_write(bmw_pkg::bmw_reg_t idx, logic [48:0] d);
        case (idx)
            bmw_pkg::REG_IMAGE_WIDTH:    m_width  = d[10:0];
            bmw_pkg::REG_IMAGE_HEIGHT:   m_height = d[10:0];
            bmw_pkg::REG_ELEMENT_ROWS:   m_erows  = d[2:0];
            bmw_pkg::REG_ELEMENT_COLS:   m_ecols  = d[2:0];
            bmw_pkg::REG_ORIGIN_ROW:     m_orow   = d[2:0];
            bmw_pkg::REG_ORIGIN_COL:     m_ocol   = d[2:0];
            bmw_pkg::REG_ELEMENT_MASK:   m_mask   = d;
            bmw_pkg::REG_OPERATION_MODE: m_mode   = d[0];
            default: ;
        endcase
        frame_restart();
    endfunction

    function automatic bit fg_at(int r, int c, int unsigned w, int unsigned h);
        if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return 0;
        return fg_ring[(r * w + c) % RING];
    endfunction

    function automatic bit morph_step(bmw_pkg::bmw_op_t op, logic [7:0] pix,
                                      output morph_res_t res);
        int unsigned w, h, er, ec, ro, co, total, ld_r, ld_c, dly, pos, k;
        int          r, c;
        bit          erode, v;
        w = clampu(m_width, 1, MAXW);
        h = clampu(m_height, 1, MAXH);
        er = clampu(m_erows, 1, MAXE);
        ec = clampu(m_ecols, 1, MAXE);
        ro = (m_orow < er) ? m_orow : er - 1;
        co = (m_ocol < ec) ? m_ocol : ec - 1;
        erode = (m_mode == bmw_pkg::MODE_ERODE);
        total = w * h;
        ld_r = erode ? er - 1 - ro : ro;
        ld_c = erode ? ec - 1 - co : co;
        dly = ld_r * w + ld_c;
        pos = in_row * w + in_col;
        if (pos < total)
            fg_ring[pos % RING] = (op == bmw_pkg::OP_PIXEL && pix != 0);
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        k = emitted;
        if (k >= total || pos < k + dly) return 0;
        r = k / w;
        c = k % w;
        if (erode)
        begin
            v = fg_at(r, c, w, h);
            for (int a = 0; a < er; a++)
                for (int b = 0; b < ec; b++)
                    if (m_mask[a * 7 + b])
                        v &= fg_at(r - ro + a, c - co + b, w, h);
        end
        else
        begin
            v = 0;
            for (int a = 0; a < er; a++)
                for (int b = 0; b < ec; b++)
                    if (m_mask[a * 7 + b])
                        v |= fg_at(r + ro - a, c + co - b, w, h);
        end
        res.rb = v;
        res.lf = (k + 1 == total);
        emitted = k + 1;
        if (emitted == total)
        begin
            in_row = 0;
            in_col = 0;
            emitted = 0;
        end
        return 1;
    endfunction

    // stimulus builders
    function automatic void push_cfg(bmw_pkg::bmw_reg_t idx, logic [48:0] d);
        pend_t p;
        p.kind = K_CFG;
        p.idx = idx;
        p.data = d;
        p.op = bmw_pkg::OP_PIXEL;
        p.pix = '0;
        pend_q.push_back(p);
    endfunction

    function automatic void push_item(bmw_pkg::bmw_op_t op, logic [7:0] pix);
        pend_t p;
        p.kind = K_ITEM;
        p.idx = bmw_pkg::REG_IMAGE_WIDTH;
        p.data = '0;
        p.op = op;
        p.pix = pix;
        pend_q.push_back(p);
    endfunction

    function automatic void push_sync();
        pend_t p;
        p.kind = K_SYNC;
        p.idx = bmw_pkg::REG_IMAGE_WIDTH;
        p.data = '0;
        p.op = bmw_pkg::OP_PIXEL;
        p.pix = '0;
        pend_q.push_back(p);
    endfunction

    function automatic void push_setup(int w, int h, int er, int ec, int ro, int co,
                                       logic [48:0] mask, bmw_pkg::bmw_mode_t mode);
        push_sync();
        push_cfg(bmw_pkg::REG_IMAGE_WIDTH, 49'(w));
        push_cfg(bmw_pkg::REG_IMAGE_HEIGHT, 49'(h));
        push_cfg(bmw_pkg::REG_ELEMENT_ROWS, 49'(er));
        push_cfg(bmw_pkg::REG_ELEMENT_COLS, 49'(ec));
        push_cfg(bmw_pkg::REG_ORIGIN_ROW, 49'(ro));
        push_cfg(bmw_pkg::REG_ORIGIN_COL, 49'(co));
        push_cfg(bmw_pkg::REG_ELEMENT_MASK, mask);
        push_cfg(bmw_pkg::REG_OPERATION_MODE, 49'(mode));
    endfunction

    function automatic logic [7:0] rand_pix();
        case ($urandom_range(0, 5))
            0, 1, 2: return 8'd0;
            3:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // one frame of random content plus the trailing items, mostly flushes, that drain it; returns items pushed
    function automatic int push_frame(int w, int h, int er, int ec, int ro, int co, bit erode);
        int cw, ch, cer, cec, cro, cco, n, dly;
        cw = clampu(w, 1, MAXW);
        ch = clampu(h, 1, MAXH);
        cer = clampu(er, 1, MAXE);
        cec = clampu(ec, 1, MAXE);
        cro = (ro < cer) ? ro : cer - 1;
        cco = (co < cec) ? co : cec - 1;
        dly = erode ? (cer - 1 - cro) * cw + (cec - 1 - cco) : cro * cw + cco;
        n = 0;
        for (int i = 0; i < cw * ch; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(bmw_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
            else
                push_item(bmw_pkg::OP_PIXEL, rand_pix());
            n++;
        end
        for (int i = 0; i < dly; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_item(bmw_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
            else
                push_item(bmw_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
            n++;
        end
        return n;
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin : drive_items
        logic        nv, nw, nop;
        logic [7:0]  npx;
        logic [2:0]  nidx;
        logic [48:0] ndat;
        pend_t       p;
        nv = item_valid;
        nw = 1'b0;
        nop = opcode;
        npx = pixel_value;
        nidx = cfg_index;
        ndat = cfg_data;
        if (rst_n && !(item_valid && !in_acc))
        begin
            nv = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pend_q.size() > 0)
            begin
                p = pend_q[0];
                case (p.kind)
                    K_ITEM:
                    begin
                        if (pend_q.size() > 150 && $urandom_range(0, 7) == 0)
                            send_gap = $urandom_range(0, 2);
                        else
                        begin
                            nv = 1'b1;
                            nop = p.op;
                            npx = p.pix;
                            void'(pend_q.pop_front());
                        end
                    end
                    K_CFG:
                    begin
                        if (quiet >= SETTLE)
                        begin
                            nw = 1'b1;
                            nidx = p.idx;
                            ndat = p.data;
                            model_write(p.idx, p.data);
                            n_cfg++;
                            void'(pend_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet >= SETTLE)
                            void'(pend_q.pop_front());
                    end
                endcase
            end
        end
        item_valid <= nv;
        opcode <= nop;
        pixel_value <= npx;
        cfg_write <= nw;
        cfg_index <= nidx;
        cfg_data <= ndat;
    end

    // receiver stall
    always @(negedge clk)
    begin : drive_stall
        logic ns;
        ns = 1'b0;
        if (rst_n)
        begin
            if (!hold_done && n_in >= 700)
            begin
                hold_done = 1;
                long_hold = 300;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                ns = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                ns = 1'b1;
            end
            else if (pend_q.size() > 150 && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 2);
                ns = 1'b1;
            end
        end
        result_stall <= ns;
    end

    // monitor and checker
    always @(posedge clk)
    begin : watch
        morph_res_t r, e;
        in_acc = 0;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                in_acc = 1;
                n_in++;
                if (morph_step(bmw_pkg::bmw_op_t'(opcode), pixel_value, r))
                    morph_q.push_back(r);
            end
            if (result_valid && !result_stall)
            begin
                n_out++;
                if (last_of_frame)
                    n_frames++;
                if (morph_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: bit=%0b last=%0b",
                                 result_bit, last_of_frame);
                end
                else
                begin
                    e = morph_q.pop_front();
                    if (result_bit !== e.rb || last_of_frame !== e.lf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at result %0d: bit exp %0b got %b, ",
                                      "last exp %0b got %b"},
                                     n_out, e.rb, result_bit, e.lf, last_of_frame);
                    end
                end
            end
            if (morph_q.size() == 0 && !item_valid)
                quiet++;
            else
                quiet = 0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, morph_q.size());
            $display("binary_morphology_window regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                 budget, w, h, er, ec, ro, co;
        logic [48:0]        mask;
        bmw_pkg::bmw_mode_t mode;
        rst_n = 0;
        item_valid = 0;
        opcode = bmw_pkg::OP_PIXEL;
        pixel_value = '0;
        result_stall = 0;
        cfg_write = 0;
        cfg_index = bmw_pkg::REG_IMAGE_WIDTH;
        cfg_data = '0;
        in_acc = 0;
        quiet = 0;
        n_in = 0; n_out = 0; n_cfg = 0; n_frames = 0; mismatches = 0;
        send_gap = 0; recv_gap = 0; long_hold = 0; hold_done = 0;
        cycles = 0;
        m_width = 1024; m_height = 1024;
        m_erows = 3; m_ecols = 3; m_orow = 1; m_ocol = 1;
        m_mask = '0; m_mode = bmw_pkg::MODE_ERODE;
        frame_restart();

        // directed: four items under the reset settings (empty element erosion), too few to release a result
        push_item(bmw_pkg::OP_PIXEL, 8'd0);
        push_item(bmw_pkg::OP_PIXEL, 8'd255);
        push_item(bmw_pkg::OP_PIXEL, 8'd1);
        push_item(bmw_pkg::OP_FLUSH, 8'd255);
        // 3x3 erosion on 4x3 with mask taps in row 0 and at row 1 col 2, flush inside frame, items past the frame
        push_setup(4, 3, 3, 3, 1, 1, 49'h1C0E07, bmw_pkg::MODE_ERODE);
        push_item(bmw_pkg::OP_PIXEL, 8'd255); push_item(bmw_pkg::OP_PIXEL, 8'd128);
        push_item(bmw_pkg::OP_PIXEL, 8'd1);   push_item(bmw_pkg::OP_PIXEL, 8'd0);
        push_item(bmw_pkg::OP_PIXEL, 8'd77);  push_item(bmw_pkg::OP_FLUSH, 8'd200);
        push_item(bmw_pkg::OP_PIXEL, 8'd254); push_item(bmw_pkg::OP_PIXEL, 8'd2);
        for (int i = 0; i < 4; i++) push_item(bmw_pkg::OP_PIXEL, 8'd170);
        for (int i = 0; i < 7; i++) push_item(bmw_pkg::OP_PIXEL, 8'd85);
        // out-of-range sizes and origins: dilation with a full mask, then with an empty element
        push_setup(0, 0, 0, 0, 7, 7, 49'h1FFFFFFFFFFFF, bmw_pkg::MODE_DILATE);
        push_item(bmw_pkg::OP_PIXEL, 8'd9); push_item(bmw_pkg::OP_PIXEL, 8'd0);
        push_setup(3, 2, 7, 7, 7, 7, '0, bmw_pkg::MODE_DILATE);
        void'(push_frame(3, 2, 7, 7, 7, 7, 0));
        push_setup(2047, 2047, 1, 7, 0, 0, 49'h7F, bmw_pkg::MODE_ERODE);
        for (int i = 0; i < 40; i++) push_item(bmw_pkg::OP_PIXEL, rand_pix());

        budget = 0;
        while (budget < RAND_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                w = $urandom_range(0, 1) ? 2047 : 1024;
                h = $urandom_range(0, 1);
                er = $urandom_range(0, 2);
            end
            else
            begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 10);
                er = $urandom_range(0, 7);
            end
            ec = $urandom_range(0, 7);
            ro = $urandom_range(0, 7);
            co = $urandom_range(0, 7);
            case ($urandom_range(0, 5))
                0:       mask = '0;
                1:       mask = '1;
                default: mask = 49'({$urandom(), $urandom()});
            endcase
            mode = bmw_pkg::bmw_mode_t'($urandom_range(0, 1));
            push_setup(w, h, er, ec, ro, co, mask, mode);
            if (w >= 1024)
            begin
                for (int i = 0; i < 60; i++)
                    push_item(bmw_pkg::bmw_op_t'($urandom_range(0, 9) == 0), rand_pix());
                budget += 60;
            end
            else
            begin
                for (int f = $urandom_range(1, 2); f > 0; f--)
                    budget += push_frame(w, h, er, ec, ro, co, mode == bmw_pkg::MODE_ERODE);
                for (int i = $urandom_range(0, 3); i > 0; i--)
                begin
                    push_item(bmw_pkg::bmw_op_t'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                    budget++;
                end
            end
            if ($urandom_range(0, 5) == 0)
                push_sync();
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pend_q.size() == 0 && !item_valid && morph_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d pixel transactions, %0d results, %0d frames, %0d register writes",
                 n_in, n_out, n_frames, n_cfg);
        $display("erosion and dilation, clamped sizes and origins, flushes, long output stall");
        if (mismatches == 0 && morph_q.size() == 0)
            $display("binary_morphology_window regression: pass");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, morph_q.size());
            $display("binary_morphology_window regression: fail");
        end
        $finish;
    end

endmodule

### binary_morphology_window.f
hw/rtl/bmw_pkg.sv
hw/rtl/bmw_config.sv
hw/rtl/bmw_front.sv
hw/rtl/bmw_queue.sv
hw/rtl/bmw_back.sv
hw/rtl/binary_morphology_window.sv
verif/binary_morphology_window_tb.sv
